// ===== hdl/pcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared types, widths and helpers of the palette colour mixer pipeline.
// ----------------------------------------------------------------------------
package pcm_pkg;

    localparam int PAL_DEPTH  = 256;
    localparam int MAP_DEPTH  = 32768;
    localparam int COLOR_W    = 8;
    localparam int KEY_W      = 15;
    localparam int CHAN_W     = 5;
    localparam int RGB_CH_W   = 6;
    localparam int NUM_CH     = 3;
    localparam int RGB_W      = NUM_CH * RGB_CH_W;
    localparam int K_W        = 7;
    localparam int PROD_W     = CHAN_W + K_W;
    localparam int ACTION_W   = 2;

    // input item packing, lowest bit first
    localparam int OFS_COLOR_A  = 0;
    localparam int OFS_COLOR_B  = OFS_COLOR_A + COLOR_W;
    localparam int OFS_RED      = OFS_COLOR_B + COLOR_W;
    localparam int OFS_GREEN    = OFS_RED + COLOR_W;
    localparam int OFS_BLUE     = OFS_GREEN + COLOR_W;
    localparam int OFS_MAP_ADDR = OFS_BLUE + COLOR_W;
    localparam int OFS_MAP_VAL  = OFS_MAP_ADDR + KEY_W;
    localparam int OFS_LEVEL    = OFS_MAP_VAL + COLOR_W;
    localparam int IN_BITS      = OFS_LEVEL + COLOR_W;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W   = 3 * COLOR_W;

    typedef logic [COLOR_W-1:0]             color_t;
    typedef logic [RGB_W-1:0]               rgb_t;
    typedef logic [KEY_W-1:0]               key_t;
    typedef logic [CHAN_W-1:0]              chan_t;
    typedef logic [K_W-1:0]                 level_t;
    typedef logic [NUM_CH-1:0][CHAN_W-1:0]  chan3_t;
    typedef logic [NUM_CH-1:0][CHAN_W:0]    sum3_t;

    localparam chan_t CHAN_MAX = 5'h1F;
    localparam color_t RAW_MAX = 8'h3F;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_PAL = 2'd0,
        ACT_LOAD_MAP = 2'd1,
        ACT_MIX      = 2'd2,
        ACT_SHADE    = 2'd3
    } action_t;

    typedef struct packed {
        action_t action;
        color_t  color_a;
        color_t  shade_level;
        rgb_t    load_rgb;
        logic    load_ok;
        key_t    map_address;
        color_t  map_value;
        logic    mix_ok;
        color_t  fix_color;
    } pcm_item_t;

    typedef struct packed {
        logic      valid;
        pcm_item_t item;
        logic      overflow;
        chan_t     over;
        color_t    add_index;
        color_t    mul_index;
    } pcm_blend_t;

    typedef struct packed {
        logic    valid;
        action_t action;
        logic    mix_ok;
        color_t  fix_color;
        logic    overflow;
        color_t  add_index;
        color_t  mul_index;
        logic    shade_ok;
        color_t  shade_index;
    } pcm_result_t;

    // 5-bit channels of a stored 6-bit-per-channel colour, blue in lane 0
    function automatic chan3_t rgb_channels(rgb_t v);
        chan3_t ch;
        for (int i = 0; i < NUM_CH; i++) begin
            ch[i] = v[i*RGB_CH_W+1 +: CHAN_W];
        end
        return ch;
    endfunction

endpackage

// ===== hdl/palette_color_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_color_mixer
// Indexed-palette pixel mixer: palette and inverse map loads, additive and
// multiplicative blend of two palette colours, and shading of one colour.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per handshake, action in s_tuser, operands and load
//   data in s_tdata. Every item, loads included, gives one result item on the
//   m_ channel (add, mul and shade index; zero where the action has none).
//   The six-stage pipeline takes one item every cycle while the receiver does
//   not stall, with one palette copy and one inverse map copy at each of its
//   two lookup points.
//   Loads take effect for every item accepted after them, with no gap.
//   Reset clears the pipeline and all palette valid flags; palette colours and
//   inverse map words hold whatever they held until written again. s_tready is
//   low while reset is held.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module palette_color_mixer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // color_a, color_b, red_in, green_in, blue_in, map_address, map_value,
    // shade_level, zero pad
    input  logic [pcm_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  logic [pcm_pkg::ACTION_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // add_color, mul_color, shade_color
    output logic [pcm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic                 en;
    logic                 accept;
    pcm_pkg::pcm_blend_t  blend;
    pcm_pkg::pcm_result_t res;
    pcm_pkg::color_t      add_color, mul_color, shade_color;

    assign en       = !res.valid || m_tready;
    assign s_tready = aresetn && en;
    assign accept   = s_tvalid && s_tready;

    pcm_blend u_blend (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (accept),
        .in_action      (pcm_pkg::action_t'(s_tuser)),
        .in_color_a     (s_tdata[pcm_pkg::OFS_COLOR_A +: pcm_pkg::COLOR_W]),
        .in_color_b     (s_tdata[pcm_pkg::OFS_COLOR_B +: pcm_pkg::COLOR_W]),
        .in_red         (s_tdata[pcm_pkg::OFS_RED +: pcm_pkg::COLOR_W]),
        .in_green       (s_tdata[pcm_pkg::OFS_GREEN +: pcm_pkg::COLOR_W]),
        .in_blue        (s_tdata[pcm_pkg::OFS_BLUE +: pcm_pkg::COLOR_W]),
        .in_map_address (s_tdata[pcm_pkg::OFS_MAP_ADDR +: pcm_pkg::KEY_W]),
        .in_map_value   (s_tdata[pcm_pkg::OFS_MAP_VAL +: pcm_pkg::COLOR_W]),
        .in_shade_level (s_tdata[pcm_pkg::OFS_LEVEL +: pcm_pkg::COLOR_W]),
        .blend          (blend)
    );

    pcm_shade u_shade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .blend   (blend),
        .result  (res)
    );

    always_comb begin
        add_color   = '0;
        mul_color   = '0;
        shade_color = '0;
        case (res.action)
            pcm_pkg::ACT_MIX: begin
                if (res.mix_ok) begin
                    if (res.overflow) begin
                        add_color = res.shade_ok ? res.shade_index : '0;
                    end else begin
                        add_color = res.add_index;
                    end
                    mul_color = res.mul_index;
                end else begin
                    add_color = res.fix_color;
                    mul_color = res.fix_color;
                end
            end
            pcm_pkg::ACT_SHADE: begin
                shade_color = res.shade_ok ? res.shade_index : '0;
            end
            default: begin
                add_color = '0;
            end
        endcase
    end

    assign m_tvalid = res.valid;
    assign m_tdata  = {shade_color, mul_color, add_color};

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result item moved during a stall");

    a_load_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (res.action == pcm_pkg::ACT_LOAD_PAL
                      || res.action == pcm_pkg::ACT_LOAD_MAP)) |-> (m_tdata == '0))
        else $error("load item gave a non-zero result");

endmodule

// ===== hdl/pcm_blend.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_blend
// Front half: palette read of both operands, channel sums and products,
// overflow pull-down and the inverse map lookup of both blend keys.
// ----------------------------------------------------------------------------
module pcm_blend (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  pcm_pkg::action_t    in_action,
    input  pcm_pkg::color_t     in_color_a,
    input  pcm_pkg::color_t     in_color_b,
    input  pcm_pkg::color_t     in_red,
    input  pcm_pkg::color_t     in_green,
    input  pcm_pkg::color_t     in_blue,
    input  pcm_pkg::key_t       in_map_address,
    input  pcm_pkg::color_t     in_map_value,
    input  pcm_pkg::color_t     in_shade_level,
    output pcm_pkg::pcm_blend_t blend
);

    pcm_pkg::rgb_t                 pal_mem [pcm_pkg::PAL_DEPTH];
    logic [pcm_pkg::PAL_DEPTH-1:0] pal_valid_reg, pal_valid_next;
    pcm_pkg::color_t               map_mem [pcm_pkg::MAP_DEPTH];

    logic                          load_ok;
    logic                          pal_wr;
    logic                          valid_a, valid_b;
    pcm_pkg::pcm_item_t            item0;

    logic                          v1_reg;
    pcm_pkg::pcm_item_t            item1_reg;
    pcm_pkg::rgb_t                 rgb_a1_reg, rgb_b1_reg;
    pcm_pkg::chan3_t               ch_a, ch_b;
    pcm_pkg::sum3_t                sum_next;
    pcm_pkg::chan3_t               mul_next;
    logic [pcm_pkg::NUM_CH-1:0][2*pcm_pkg::CHAN_W-1:0] prod;

    logic                          v2_reg;
    pcm_pkg::pcm_item_t            item2_reg;
    pcm_pkg::sum3_t                sum2_reg;
    pcm_pkg::chan3_t               mul2_reg;
    logic [pcm_pkg::CHAN_W:0]      sum_max;
    logic                          overflow;
    pcm_pkg::chan_t                over;
    pcm_pkg::chan3_t               add_key;
    logic                          map_wr;

    logic                          v3_reg;
    pcm_pkg::pcm_item_t            item3_reg;
    logic                          ovf3_reg;
    pcm_pkg::chan_t                over3_reg;
    pcm_pkg::color_t               add3_reg, mul3_reg;

    // entry stage: palette write and operand flags
    always_comb begin
        valid_a = pal_valid_reg[in_color_a];
        valid_b = pal_valid_reg[in_color_b];
        load_ok = (in_red <= pcm_pkg::RAW_MAX) && (in_green <= pcm_pkg::RAW_MAX)
                  && (in_blue <= pcm_pkg::RAW_MAX);
        pal_wr  = en && in_valid && (in_action == pcm_pkg::ACT_LOAD_PAL);

        item0.action      = in_action;
        item0.color_a     = in_color_a;
        item0.shade_level = in_shade_level;
        item0.load_ok     = load_ok;
        item0.load_rgb    = load_ok ? {in_red[pcm_pkg::RGB_CH_W-1:0],
                                       in_green[pcm_pkg::RGB_CH_W-1:0],
                                       in_blue[pcm_pkg::RGB_CH_W-1:0]} : '0;
        item0.map_address = in_map_address;
        item0.map_value   = in_map_value;
        item0.mix_ok      = valid_a && valid_b;
        item0.fix_color   = valid_b ? in_color_b : in_color_a;

        pal_valid_next = pal_valid_reg;
        if (pal_wr) begin
            pal_valid_next[in_color_a] = load_ok;
        end
    end

    // stage 1: channel sums and products
    always_comb begin
        ch_a = pcm_pkg::rgb_channels(rgb_a1_reg);
        ch_b = pcm_pkg::rgb_channels(rgb_b1_reg);
        for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
            sum_next[i] = {1'b0, ch_a[i]} + {1'b0, ch_b[i]};
            prod[i]     = {{pcm_pkg::CHAN_W{1'b0}}, ch_a[i]}
                          * {{pcm_pkg::CHAN_W{1'b0}}, ch_b[i]};
            mul_next[i] = prod[i][2*pcm_pkg::CHAN_W-1 -: pcm_pkg::CHAN_W];
        end
    end

    // stage 2: pull every sum down by the excess of the largest one
    always_comb begin
        sum_max = sum2_reg[0];
        if (sum2_reg[1] > sum_max) begin
            sum_max = sum2_reg[1];
        end
        if (sum2_reg[2] > sum_max) begin
            sum_max = sum2_reg[2];
        end
        overflow = sum_max[pcm_pkg::CHAN_W];
        over     = overflow ? pcm_pkg::chan_t'(sum_max - {1'b0, pcm_pkg::CHAN_MAX}) : '0;
        for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
            if (sum2_reg[i] > {1'b0, over}) begin
                add_key[i] = pcm_pkg::chan_t'(sum2_reg[i] - {1'b0, over});
            end else begin
                add_key[i] = '0;
            end
        end
        map_wr = en && v2_reg && (item2_reg.action == pcm_pkg::ACT_LOAD_MAP);
    end

    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            pal_mem[in_color_a] <= item0.load_rgb;
        end
        if (en) begin
            rgb_a1_reg <= pal_mem[in_color_a];
            rgb_b1_reg <= pal_mem[in_color_b];
        end
    end

    always_ff @(posedge aclk) begin
        if (map_wr) begin
            map_mem[item2_reg.map_address] <= item2_reg.map_value;
        end
        if (en) begin
            add3_reg <= map_mem[add_key];
            mul3_reg <= map_mem[mul2_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            pal_valid_reg <= '0;
        end else begin
            pal_valid_reg <= pal_valid_next;
            if (en) begin
                v1_reg <= in_valid;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item1_reg <= item0;
            item2_reg <= item1_reg;
            sum2_reg  <= sum_next;
            mul2_reg  <= mul_next;
            item3_reg <= item2_reg;
            ovf3_reg  <= overflow;
            over3_reg <= over;
        end
    end

    always_comb begin
        blend.valid     = v3_reg;
        blend.item      = item3_reg;
        blend.overflow  = ovf3_reg;
        blend.over      = over3_reg;
        blend.add_index = add3_reg;
        blend.mul_index = mul3_reg;
    end

endmodule

// ===== hdl/pcm_shade.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcm_shade
// Back half: palette read of the colour to shade, darken or lighten of each
// channel, and the inverse map lookup of the shaded key.
// ----------------------------------------------------------------------------
module pcm_shade (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  pcm_pkg::pcm_blend_t  blend,
    output pcm_pkg::pcm_result_t result
);

    typedef struct packed {
        pcm_pkg::action_t action;
        logic             mix_ok;
        pcm_pkg::color_t  fix_color;
        logic             overflow;
        pcm_pkg::color_t  add_index;
        pcm_pkg::color_t  mul_index;
        pcm_pkg::key_t    map_address;
        pcm_pkg::color_t  map_value;
    } tail_t;

    pcm_pkg::rgb_t                 pal_mem [pcm_pkg::PAL_DEPTH];
    logic [pcm_pkg::PAL_DEPTH-1:0] pal_valid_reg, pal_valid_next;
    pcm_pkg::color_t               map_mem [pcm_pkg::MAP_DEPTH];

    logic                          shade_act;
    pcm_pkg::color_t               idx;
    logic                          lighten;
    pcm_pkg::level_t               k;
    logic                          pal_wr;
    tail_t                         tail3;

    logic                          v4_reg;
    tail_t                         tail4_reg;
    pcm_pkg::rgb_t                 rgb4_reg;
    logic                          ok4_reg;
    logic                          lighten4_reg;
    pcm_pkg::level_t               k4_reg;
    pcm_pkg::chan3_t               ch4, term;
    pcm_pkg::chan3_t               step_next;
    logic [pcm_pkg::NUM_CH-1:0][pcm_pkg::PROD_W-1:0] prod;

    logic                          v5_reg;
    tail_t                         tail5_reg;
    logic                          ok5_reg;
    logic                          lighten5_reg;
    pcm_pkg::chan3_t               ch5_reg, step5_reg;
    pcm_pkg::chan3_t               shade_key;
    logic                          map_wr;

    logic                          v6_reg;
    tail_t                         tail6_reg;
    logic                          ok6_reg;
    pcm_pkg::color_t               look6_reg;

    // stage 3: pick the colour and step, palette copy write
    always_comb begin
        shade_act = blend.item.action == pcm_pkg::ACT_SHADE;
        idx       = shade_act ? blend.item.color_a : blend.add_index;
        lighten   = shade_act ? blend.item.shade_level[pcm_pkg::COLOR_W-1] : 1'b1;
        k         = shade_act ? blend.item.shade_level[pcm_pkg::K_W-1:0]
                              : pcm_pkg::level_t'(blend.over);
        pal_wr    = en && blend.valid && (blend.item.action == pcm_pkg::ACT_LOAD_PAL);

        tail3.action      = blend.item.action;
        tail3.mix_ok      = blend.item.mix_ok;
        tail3.fix_color   = blend.item.fix_color;
        tail3.overflow    = blend.overflow;
        tail3.add_index   = blend.add_index;
        tail3.mul_index   = blend.mul_index;
        tail3.map_address = blend.item.map_address;
        tail3.map_value   = blend.item.map_value;

        pal_valid_next = pal_valid_reg;
        if (pal_wr) begin
            pal_valid_next[blend.item.color_a] = blend.item.load_ok;
        end
    end

    // stage 4: scale the distance to black or to white
    always_comb begin
        ch4 = pcm_pkg::rgb_channels(rgb4_reg);
        for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
            term[i]      = lighten4_reg ? pcm_pkg::CHAN_MAX - ch4[i] : ch4[i];
            prod[i]      = {{pcm_pkg::K_W{1'b0}}, term[i]}
                           * {{pcm_pkg::CHAN_W{1'b0}}, k4_reg};
            step_next[i] = prod[i][pcm_pkg::PROD_W-1 -: pcm_pkg::CHAN_W];
        end
    end

    // stage 5: shaded key
    always_comb begin
        for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
            shade_key[i] = lighten5_reg ? pcm_pkg::chan_t'(ch5_reg[i] + step5_reg[i])
                                        : step5_reg[i];
        end
        map_wr = en && v5_reg && (tail5_reg.action == pcm_pkg::ACT_LOAD_MAP);
    end

    always_ff @(posedge aclk) begin
        if (pal_wr) begin
            pal_mem[blend.item.color_a] <= blend.item.load_rgb;
        end
        if (en) begin
            rgb4_reg <= pal_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (map_wr) begin
            map_mem[tail5_reg.map_address] <= tail5_reg.map_value;
        end
        if (en) begin
            look6_reg <= map_mem[shade_key];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            pal_valid_reg <= '0;
        end else begin
            pal_valid_reg <= pal_valid_next;
            if (en) begin
                v4_reg <= blend.valid;
                v5_reg <= v4_reg;
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tail4_reg    <= tail3;
            ok4_reg      <= pal_valid_reg[idx];
            lighten4_reg <= lighten;
            k4_reg       <= k;
            tail5_reg    <= tail4_reg;
            ok5_reg      <= ok4_reg;
            lighten5_reg <= lighten4_reg;
            ch5_reg      <= ch4;
            step5_reg    <= step_next;
            tail6_reg    <= tail5_reg;
            ok6_reg      <= ok5_reg;
        end
    end

    always_comb begin
        result.valid       = v6_reg;
        result.action      = tail6_reg.action;
        result.mix_ok      = tail6_reg.mix_ok;
        result.fix_color   = tail6_reg.fix_color;
        result.overflow    = tail6_reg.overflow;
        result.add_index   = tail6_reg.add_index;
        result.mul_index   = tail6_reg.mul_index;
        result.shade_ok    = ok6_reg;
        result.shade_index = look6_reg;
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for palette_color_mixer. Palette and inverse map loads,
// mixes and shades are sent as stream items in bursts while the result side
// stalls on a rotating pattern. A local palette and inverse map copy predicts
// each result item that the directed list does not fix; all are compared field
// by field in order. Each inverse map key a mix or shade will read is loaded first.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 3;
    localparam int TOTAL_ITEMS  = 950;
    localparam int DRAIN_CYCLES = 12;
    localparam int REPORT_CAP   = 100;
    localparam int CHAN_TOP     = 31;
    localparam int LIGHT_BASE   = 128;

    typedef struct packed {
        pcm_pkg::action_t action;
        pcm_pkg::color_t  shade_level;
        pcm_pkg::color_t  map_value;
        pcm_pkg::key_t    map_address;
        pcm_pkg::color_t  blue_in;
        pcm_pkg::color_t  green_in;
        pcm_pkg::color_t  red_in;
        pcm_pkg::color_t  color_b;
        pcm_pkg::color_t  color_a;
    } pixel_op_t;

    // add_color in the lowest byte, as on m_tdata
    typedef struct packed {
        pcm_pkg::color_t shade_color;
        pcm_pkg::color_t mul_color;
        pcm_pkg::color_t add_color;
    } mix_out_t;

    typedef struct {
        pixel_op_t op;
        bit        typed;
        mix_out_t  want;
    } stim_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pcm_pkg::IN_DATA_W-1:0]   s_tdata  = '0;
    logic [pcm_pkg::ACTION_W-1:0]    s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pcm_pkg::OUT_DATA_W-1:0]  m_tdata;

    palette_color_mixer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    bit [pcm_pkg::RGB_W-1:0]   pal_rgb [pcm_pkg::PAL_DEPTH];
    bit                        pal_ok  [pcm_pkg::PAL_DEPTH];
    bit [pcm_pkg::COLOR_W-1:0] inv_map [pcm_pkg::MAP_DEPTH];
    bit                        map_set [pcm_pkg::MAP_DEPTH];

    mix_out_t pending_indices [$];
    int       unmapped_key   = -1;
    bit       mix_overflowed = 1'b0;
    int       burst_left     = 1;

    int n_pal = 0, n_map = 0, n_mix = 0, n_shade = 0, n_over = 0;
    int n_checked = 0, n_fail = 0;

    string           field_name [3]  = '{"add_color", "mul_color", "shade_color"};
    pcm_pkg::color_t level_marks [4] = '{8'd0, 8'd127, 8'd128, 8'd255};

    function automatic int chan5(int idx, int lane);
        return int'((pal_rgb[idx] >> (lane * pcm_pkg::RGB_CH_W + 1))
                    & (pcm_pkg::RGB_W)'(CHAN_TOP));
    endfunction

    function automatic int key_of(int r, int g, int b);
        return (r << (2 * pcm_pkg::CHAN_W)) | (g << pcm_pkg::CHAN_W) | b;
    endfunction

    function automatic pcm_pkg::color_t map_read(int key);
        if (!map_set[key] && unmapped_key < 0) begin
            unmapped_key = key;
        end
        return inv_map[key];
    endfunction

    function automatic pcm_pkg::color_t shade_of(int idx, int level);
        int c [pcm_pkg::NUM_CH];
        if (!pal_ok[idx]) begin
            return '0;
        end
        for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
            c[i] = chan5(idx, i);
            if (level < LIGHT_BASE) begin
                c[i] = (c[i] * level) >> pcm_pkg::K_W;
            end else begin
                c[i] = c[i] + (((CHAN_TOP - c[i]) * (level - LIGHT_BASE)) >> pcm_pkg::K_W);
            end
        end
        return map_read(key_of(c[2], c[1], c[0]));
    endfunction

    function automatic mix_out_t color_result(pixel_op_t op);
        mix_out_t        res;
        int              a [pcm_pkg::NUM_CH];
        int              b [pcm_pkg::NUM_CH];
        int              s [pcm_pkg::NUM_CH];
        int              peak;
        int              over;
        pcm_pkg::color_t sat;
        res            = '0;
        peak           = 0;
        mix_overflowed = 1'b0;
        case (op.action)
            pcm_pkg::ACT_MIX: begin
                if (pal_ok[op.color_a] && pal_ok[op.color_b]) begin
                    for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
                        a[i] = chan5(op.color_a, i);
                        b[i] = chan5(op.color_b, i);
                        s[i] = a[i] + b[i];
                        if (s[i] > peak) begin
                            peak = s[i];
                        end
                    end
                    if (peak <= CHAN_TOP) begin
                        res.add_color = map_read(key_of(s[2], s[1], s[0]));
                    end else begin
                        // pull every sum down by the overshoot, then lighten by it
                        over = peak - CHAN_TOP;
                        for (int i = 0; i < pcm_pkg::NUM_CH; i++) begin
                            s[i] = (s[i] > over) ? s[i] - over : 0;
                        end
                        sat            = map_read(key_of(s[2], s[1], s[0]));
                        res.add_color  = shade_of(sat, LIGHT_BASE + over);
                        mix_overflowed = 1'b1;
                    end
                    res.mul_color = map_read(key_of((a[2] * b[2]) >> pcm_pkg::CHAN_W,
                                                    (a[1] * b[1]) >> pcm_pkg::CHAN_W,
                                                    (a[0] * b[0]) >> pcm_pkg::CHAN_W));
                end else if (pal_ok[op.color_b]) begin
                    res.add_color = op.color_b;
                    res.mul_color = op.color_b;
                end else begin
                    res.add_color = op.color_a;
                    res.mul_color = op.color_a;
                end
            end
            pcm_pkg::ACT_SHADE: begin
                res.shade_color = shade_of(op.color_a, op.shade_level);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void apply_load(pixel_op_t op);
        case (op.action)
            pcm_pkg::ACT_LOAD_PAL: begin
                if (op.red_in <= pcm_pkg::RAW_MAX && op.green_in <= pcm_pkg::RAW_MAX
                    && op.blue_in <= pcm_pkg::RAW_MAX) begin
                    pal_rgb[op.color_a] = {op.red_in[5:0], op.green_in[5:0], op.blue_in[5:0]};
                    pal_ok[op.color_a]  = 1'b1;
                end else begin
                    pal_rgb[op.color_a] = '0;
                    pal_ok[op.color_a]  = 1'b0;
                end
            end
            pcm_pkg::ACT_LOAD_MAP: begin
                inv_map[op.map_address] = op.map_value;
                map_set[op.map_address] = 1'b1;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic pcm_pkg::color_t pick_color(bit want_valid);
        pcm_pkg::color_t idx;
        idx = pcm_pkg::color_t'($urandom);
        for (int t = 0; want_valid && t < 16 && !pal_ok[idx]; t++) begin
            idx = pcm_pkg::color_t'($urandom);
        end
        return idx;
    endfunction

    function automatic pixel_op_t noise_op(pcm_pkg::action_t action);
        pixel_op_t op;
        op.action = action;
        {op.shade_level, op.map_value, op.map_address, op.blue_in, op.green_in,
         op.red_in, op.color_b, op.color_a} = (pcm_pkg::IN_BITS)'({$urandom, $urandom,
                                                                    $urandom});
        return op;
    endfunction

    function automatic pixel_op_t op_pal(pcm_pkg::color_t idx, pcm_pkg::color_t r,
                                         pcm_pkg::color_t g, pcm_pkg::color_t b);
        pixel_op_t op;
        op          = noise_op(pcm_pkg::ACT_LOAD_PAL);
        op.color_a  = idx;
        op.red_in   = r;
        op.green_in = g;
        op.blue_in  = b;
        return op;
    endfunction

    function automatic pixel_op_t op_map(pcm_pkg::key_t key, pcm_pkg::color_t value);
        pixel_op_t op;
        op             = noise_op(pcm_pkg::ACT_LOAD_MAP);
        op.map_address = key;
        op.map_value   = value;
        return op;
    endfunction

    function automatic pixel_op_t op_mix(pcm_pkg::color_t a, pcm_pkg::color_t b);
        pixel_op_t op;
        op         = noise_op(pcm_pkg::ACT_MIX);
        op.color_a = a;
        op.color_b = b;
        return op;
    endfunction

    function automatic pixel_op_t op_shade(pcm_pkg::color_t c, pcm_pkg::color_t level);
        pixel_op_t op;
        op             = noise_op(pcm_pkg::ACT_SHADE);
        op.color_a     = c;
        op.shade_level = level;
        return op;
    endfunction

    function automatic mix_out_t outs(pcm_pkg::color_t add_c, pcm_pkg::color_t mul_c,
                                      pcm_pkg::color_t shade_c);
        return {shade_c, mul_c, add_c};
    endfunction

    task automatic issue(pixel_op_t op, bit typed, mix_out_t want);
        mix_out_t res;
        res = color_result(op);
        apply_load(op);
        case (op.action)
            pcm_pkg::ACT_LOAD_PAL: n_pal++;
            pcm_pkg::ACT_LOAD_MAP: n_map++;
            pcm_pkg::ACT_MIX:      n_mix++;
            default:               n_shade++;
        endcase
        if (mix_overflowed) begin
            n_over++;
        end
        pending_indices.push_back(typed ? want : res);
        s_tdata  <= {{(pcm_pkg::IN_DATA_W - pcm_pkg::IN_BITS){1'b0}},
                     op[pcm_pkg::IN_BITS-1:0]};
        s_tuser  <= op.action;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // load every inverse map key the item will read before sending it
    task automatic submit(pixel_op_t op, bit typed, mix_out_t want);
        if (op.action == pcm_pkg::ACT_MIX || op.action == pcm_pkg::ACT_SHADE) begin
            do begin
                unmapped_key = -1;
                void'(color_result(op));
                if (unmapped_key >= 0) begin
                    issue(op_map(pcm_pkg::key_t'(unmapped_key),
                                 pick_color($urandom_range(0, 3) != 0)),
                          1'b0, '0);
                end
            end while (unmapped_key >= 0);
        end
        issue(op, typed, want);
    endtask

    always @(posedge aclk) begin : result_check
        mix_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_indices.size() == 0) begin
                n_fail++;
                if (n_fail <= REPORT_CAP) begin
                    $display("%0t: unexpected result item, expected none, actual %h",
                             $time, m_tdata);
                end
            end else begin
                want = pending_indices.pop_front();
                n_checked++;
                for (int i = 0; i < 3; i++) begin
                    if (m_tdata[i*pcm_pkg::COLOR_W +: pcm_pkg::COLOR_W]
                        !== want[i*pcm_pkg::COLOR_W +: pcm_pkg::COLOR_W]) begin
                        n_fail++;
                        if (n_fail <= REPORT_CAP) begin
                            $display("%0t: %s expected %0d actual %0d", $time, field_name[i],
                                     want[i*pcm_pkg::COLOR_W +: pcm_pkg::COLOR_W],
                                     m_tdata[i*pcm_pkg::COLOR_W +: pcm_pkg::COLOR_W]);
                        end
                    end
                end
            end
        end
    end

    // receiver stall pattern, chosen at random from four modes
    int unsigned rx_tick = 0;
    int unsigned rx_mode = 0;
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 97 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom);
            2:       m_tready <= (rx_tick % 4 == 0);
            default: m_tready <= (rx_tick % 16 >= 11);
        endcase
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        stim_row_t       directed [$];
        pixel_op_t       op;
        int              roll;
        pcm_pkg::color_t lvl;

        directed.push_back('{op_mix(5, 9),               1'b1, outs(5, 5, 0)});
        directed.push_back('{op_shade(7, 200),           1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(0, 0, 0, 0),         1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(255, 63, 63, 63),    1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(10, 64, 0, 0),       1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(11, 0, 255, 0),      1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(12, 0, 0, 128),      1'b1, outs(0, 0, 0)});
        directed.push_back('{op_map(0, 0),               1'b1, outs(0, 0, 0)});
        directed.push_back('{op_map(15'h7FFF, 255),      1'b1, outs(0, 0, 0)});
        directed.push_back('{op_mix(255, 10),            1'b1, outs(255, 255, 0)});
        directed.push_back('{op_mix(11, 255),            1'b1, outs(255, 255, 0)});
        directed.push_back('{op_mix(0, 0),               1'b0, '0});
        directed.push_back('{op_mix(0, 255),             1'b0, '0});
        directed.push_back('{op_mix(255, 255),           1'b0, '0});
        directed.push_back('{op_shade(255, 0),           1'b0, '0});
        directed.push_back('{op_shade(255, 127),         1'b0, '0});
        directed.push_back('{op_shade(255, 128),         1'b0, '0});
        directed.push_back('{op_shade(0, 255),           1'b0, '0});
        directed.push_back('{op_shade(12, 255),          1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(20, 63, 0, 33),      1'b1, outs(0, 0, 0)});
        directed.push_back('{op_pal(21, 1, 62, 32),      1'b1, outs(0, 0, 0)});
        directed.push_back('{op_mix(20, 21),             1'b0, '0});
        directed.push_back('{op_mix(20, 20),             1'b0, '0});
        directed.push_back('{op_pal(255, 63, 63, 64),    1'b1, outs(0, 0, 0)});
        directed.push_back('{op_mix(255, 21),            1'b1, outs(21, 21, 0)});
        directed.push_back('{op_shade(255, 255),         1'b1, outs(0, 0, 0)});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            submit(directed[i].op, directed[i].typed, directed[i].want);
        end

        while (n_pal + n_map + n_mix + n_shade < TOTAL_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 22) begin
                op = op_pal(pcm_pkg::color_t'($urandom),
                            pcm_pkg::color_t'($urandom_range(0, 63)),
                            pcm_pkg::color_t'($urandom_range(0, 63)),
                            pcm_pkg::color_t'($urandom_range(0, 63)));
                if ($urandom_range(0, 7) == 0) begin
                    op.red_in   = pcm_pkg::color_t'($urandom);
                    op.green_in = pcm_pkg::color_t'($urandom);
                    op.blue_in  = pcm_pkg::color_t'($urandom);
                end
            end else if (roll < 30) begin
                op = op_map(pcm_pkg::key_t'($urandom), pick_color(1'b1));
            end else if (roll < 72) begin
                op = op_mix(pick_color(roll < 66), pick_color(roll < 68));
            end else begin
                lvl = ($urandom_range(0, 7) == 0) ? level_marks[$urandom_range(0, 3)]
                                                  : pcm_pkg::color_t'($urandom);
                op  = op_shade(pick_color(roll < 94), lvl);
            end
            submit(op, 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_indices.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d palette loads, %0d inverse map loads, %0d mixes (%0d overflowing)",
                 n_pal, n_map, n_mix, n_over);
        $display("and %0d shades; %0d result items checked, %0d mismatches",
                 n_shade, n_checked, n_fail);
        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== palette_color_mixer.f =====
hdl/pcm_pkg.sv
hdl/pcm_blend.sv
hdl/pcm_shade.sv
hdl/palette_color_mixer.sv
tb/testbench.sv
